### hdl/mucc_pkg.sv
package mucc_pkg;

  // fixed field widths of the request and configuration ports
  localparam int FIELD_W = 5;
  localparam int CNT_W   = 6;

  localparam logic [CNT_W-1:0] VC_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // request handed from the channel to the sequencer
  typedef struct packed {
    cmd_t               command;
    logic [FIELD_W-1:0] vertex_a;
    logic [FIELD_W-1:0] vertex_b;
    logic [FIELD_W-1:0] factor_index;
  } mucc_req_t;

  // finished result offered by the sequencer
  typedef struct packed {
    logic valid;
    logic short_cycle;
  } mucc_rsp_t;

endpackage

### hdl/mucc_core.sv
module mucc_core
  import mucc_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  mucc_req_t        req,
  input  logic [CNT_W-1:0] n_eff,
  input  logic [CNT_W-1:0] factor_cnt,
  input  logic             out_free,
  output logic             idle,
  output mucc_rsp_t        rsp
);

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = $clog2(MAX_VERTICES / 2 + 1);
  localparam int LEN_W = CNT_W + 1;
  localparam logic [SW-1:0]    HALF_STEPS = SW'(MAX_VERTICES / 2);
  localparam logic [CNT_W-1:0] MAX_V      = CNT_W'(MAX_VERTICES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WR2   = 6'b000010,
    S_GSEL  = 6'b000100,
    S_FSTEP = 6'b001000,
    S_GSTEP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [VW-1:0]           a_r, b_r, f_r, g_r;
  logic [SW-1:0]           step_r;
  logic [MAX_VERTICES-1:0] mask_f_r, mask_g_r;
  logic                    res_r;

  // covered vertices per factor; a set bit also marks the partner entry valid
  logic [MAX_VERTICES-1:0] masks_r [MAX_VERTICES];

  // partner memory, one entry per factor and vertex
  logic [VW-1:0] partner_mem [DEPTH];
  logic [VW-1:0] rd_q;

  logic          mem_we, rd_en;
  logic [AW-1:0] mem_waddr, rd_addr;
  logic [VW-1:0] mem_wdata;

  logic [VW-1:0]           in_a, in_b, in_f, mask_idx;
  logic [MAX_VERTICES-1:0] mask_rd, ends_in, ends_r;
  logic                    req_ok;
  logic                    g_inc, walk_go, step_inc, set_hit;
  logic [LEN_W-1:0]        cyc_len;

  assign in_a = req.vertex_a[VW-1:0];
  assign in_b = req.vertex_b[VW-1:0];
  assign in_f = req.factor_index[VW-1:0];

  // reject requests with a vertex outside the table or a factor not below MAX_VERTICES - 1
  assign req_ok = (CNT_W'(req.vertex_a) < MAX_V) && (CNT_W'(req.vertex_b) < MAX_V) &&
                  ((CNT_W'(req.factor_index) + CNT_W'(1)) < MAX_V);

  assign ends_in = (MAX_VERTICES'(1) << in_a) | (MAX_VERTICES'(1) << in_b);
  assign ends_r  = (MAX_VERTICES'(1) << a_r) | (MAX_VERTICES'(1) << b_r);

  // single mask read port: request factor when idle, walked factor otherwise
  assign mask_idx = (state_r == S_IDLE) ? in_f : g_r;
  assign mask_rd  = masks_r[mask_idx];

  // cycle length after the current number of alternating steps
  assign cyc_len = (LEN_W'(step_r) << 1) + LEN_W'(2);

  assign idle            = (state_r == S_IDLE);
  assign rsp.valid       = (state_r == S_DONE);
  assign rsp.short_cycle = res_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    g_inc     = 1'b0;
    walk_go   = 1'b0;
    step_inc  = 1'b0;
    set_hit   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (!req_ok) begin
            state_nxt = S_DONE;
          end else begin
            case (req.command)
              CMD_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = {in_f, in_a};
                mem_wdata = in_b;
                state_nxt = S_WR2;
              end
              CMD_CHECK: state_nxt = S_GSEL;
              default:   state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = {f_r, b_r};
        mem_wdata = a_r;
        state_nxt = S_DONE;
      end
      S_GSEL: begin
        if (CNT_W'(g_r) >= factor_cnt) begin
          state_nxt = S_DONE;
        end else if ((g_r == f_r) || ((mask_rd & ends_r) != ends_r)) begin
          g_inc = 1'b1;
        end else begin
          walk_go   = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = {g_r, b_r};
          state_nxt = S_FSTEP;
        end
      end
      S_FSTEP: begin
        if ((step_r != '0) && (rd_q == a_r)) begin
          if (cyc_len < LEN_W'(n_eff)) begin
            set_hit   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            g_inc     = 1'b1;
            state_nxt = S_GSEL;
          end
        end else if ((step_r == HALF_STEPS) || !mask_f_r[rd_q]) begin
          g_inc     = 1'b1;
          state_nxt = S_GSEL;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = {f_r, rd_q};
          state_nxt = S_GSTEP;
        end
      end
      S_GSTEP: begin
        if (!mask_g_r[rd_q]) begin
          g_inc     = 1'b1;
          state_nxt = S_GSEL;
        end else begin
          step_inc  = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = {g_r, rd_q};
          state_nxt = S_FSTEP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and covered masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        masks_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (idle && start && req_ok) begin
        if (req.command == CMD_PLACE) begin
          masks_r[in_f] <= mask_rd | ends_in;
        end else if (req.command == CMD_REMOVE) begin
          masks_r[in_f] <= mask_rd & ~ends_in;
        end
      end
    end
  end

  // latch the request and advance the walk counters
  always_ff @(posedge clk) begin
    if (idle && start) begin
      a_r      <= in_a;
      b_r      <= in_b;
      f_r      <= in_f;
      mask_f_r <= mask_rd;
      g_r      <= '0;
      res_r    <= 1'b0;
    end
    if (g_inc) begin
      g_r <= g_r + VW'(1);
    end
    if (walk_go) begin
      mask_g_r <= mask_rd;
      step_r   <= '0;
    end
    if (step_inc) begin
      step_r <= step_r + SW'(1);
    end
    if (set_hit) begin
      res_r <= 1'b1;
    end
  end

  // partner memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      partner_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= partner_mem[rd_addr];
    end
  end

endmodule

### hdl/matching_union_short_cycle_check_unit.sv
// Short-cycle checker over a partial 1-factorization of a complete graph.
// Input channel (in_valid / in_stall) carries one request: a command, two
// vertices and a factor. Place writes the edge into the factor, remove
// clears it, check walks the f/g alternating path for every other factor
// g covering both ends. Each request gives exactly one result on the
// output channel (out_valid / out_stall); out_short_cycle is 1 only when a
// check closes a cycle shorter than the vertex count.
// cfg_wr_en / cfg_wr_data load the vertex count, to be changed only idle.
// Remove and ignored requests go from accept straight to the done state;
// place adds a second partner write first. A check selects in turn each
// factor below vertex_count - 1 and walks each usable one in alternating
// steps (at most MAX_VERTICES / 2 steps), with one partner lookup per
// cycle from the partner memory.
// One request is in work at a time; without stalls the next one is taken as
// the result appears, so a new request waits for the last result. A stalled
// result sits in the output register; the sequencer takes one more request
// and holds its result, with in_stall high, until that register frees.
// Reset holds in_stall high and clears the covered masks, which also mark
// partner entries valid, so no memory clearing pass is needed; vertex count
// resets to 32.
module matching_union_short_cycle_check_unit
  import mucc_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [FIELD_W-1:0] in_vertex_a,
  input  logic [FIELD_W-1:0] in_vertex_b,
  input  logic [FIELD_W-1:0] in_factor_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_short_cycle,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_wr_data
);

  localparam logic [CNT_W-1:0] MAX_V = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0] vertex_count_r;
  logic [CNT_W-1:0] n_eff, factor_cnt;
  logic             out_valid_r, out_sc_r;
  logic             core_idle, start, out_free;
  mucc_req_t        req;
  mucc_rsp_t        rsp;

  // clamp vertex count to the table size
  assign n_eff      = (vertex_count_r > MAX_V) ? MAX_V : vertex_count_r;
  assign factor_cnt = (n_eff == '0) ? '0 : n_eff - CNT_W'(1);

  // hold requests off during reset and while the sequencer is busy
  assign in_stall = !core_idle || !rst_n;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign req.command      = cmd_t'(in_command);
  assign req.vertex_a     = in_vertex_a;
  assign req.vertex_b     = in_vertex_b;
  assign req.factor_index = in_factor_index;

  mucc_core #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req        (req),
    .n_eff      (n_eff),
    .factor_cnt (factor_cnt),
    .out_free   (out_free),
    .idle       (core_idle),
    .rsp        (rsp)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VC_RESET;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && out_free) begin
      out_sc_r <= rsp.short_cycle;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_short_cycle = out_sc_r;

endmodule

### hdl/mucc_checker.sv
module mucc_checker
  import mucc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_short_cycle
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_short_cycle))
    else $error("result changed while stalled");

  // an accepted request keeps the sequencer busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while sequencer not busy");

  // a new result only follows a cycle in which a request was in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

endmodule

bind matching_union_short_cycle_check_unit mucc_checker u_mucc_checker (.*);
